FILE: rtl/isl_pkg.sv
// ----------------------------------------------------------------------------
// Indexed shift list package
// Shared sizes, request and status codes, and the command record that the
// front end hands to the execution engine.
// ----------------------------------------------------------------------------
package isl_pkg;

	// Storage geometry.
	localparam int CAPACITY      = 64;
	localparam int ELEMENT_WIDTH = 32;
	localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W         = $clog2(CAPACITY + 1);

	// Field widths on the stream ports.
	localparam int TYPE_W        = 3;
	localparam int POS_W         = 7;
	localparam int ELEM_FIELD_W  = 32;
	localparam int STATUS_W      = 2;
	localparam int DATA_FIELD_W  = 32;
	localparam int COUNT_FIELD_W = 7;
	localparam int IN_W          = TYPE_W + POS_W + ELEM_FIELD_W;
	localparam int IN_TDATA_W    = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W         = STATUS_W + DATA_FIELD_W + COUNT_FIELD_W;
	localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;

	// Width at which positions are compared with the element count.
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Two-level read select: groups of cells, then one group.
	localparam int GRP  = 8;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	// Command queue between front end and engine.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Request codes as they arrive on the input stream.
	localparam logic [TYPE_W-1:0] RT_PUSH   = 3'd0;
	localparam logic [TYPE_W-1:0] RT_POP    = 3'd1;
	localparam logic [TYPE_W-1:0] RT_INSERT = 3'd2;
	localparam logic [TYPE_W-1:0] RT_REMOVE = 3'd3;
	localparam logic [TYPE_W-1:0] RT_GET    = 3'd4;
	localparam logic [TYPE_W-1:0] RT_SET    = 3'd5;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_INSERT,
		OP_REMOVE,
		OP_GET,
		OP_SET,
		OP_NOP
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_EMPTY,
		ST_BOUNDS,
		ST_FULL
	} status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_EXEC
	} bstate_t;

	typedef struct packed {
		op_t                      op;
		logic [POS_W-1:0]         pos;
		logic [ELEMENT_WIDTH-1:0] elem;
	} cmd_t;

endpackage

FILE: rtl/isl_front.sv
// ----------------------------------------------------------------------------
// Indexed shift list front end
// Accepts requests from the input stream, unpacks the fields and classifies
// the request code into an operation for the command queue.
// ----------------------------------------------------------------------------
module isl_front (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0 up: req_type (3), position (7), element (32), zero fill.
	input  logic [isl_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             q_valid,
	input  logic                             q_ready,
	output isl_pkg::cmd_t                    q_cmd
);

	logic [isl_pkg::TYPE_W-1:0]       req_type;
	logic [isl_pkg::POS_W-1:0]        position;
	logic [isl_pkg::ELEM_FIELD_W-1:0] element;

	// Field extraction.
	assign req_type = s_tdata[isl_pkg::TYPE_W-1:0];
	assign position = s_tdata[isl_pkg::TYPE_W +: isl_pkg::POS_W];
	assign element  = s_tdata[isl_pkg::TYPE_W + isl_pkg::POS_W +: isl_pkg::ELEM_FIELD_W];

	// A request enters the queue whenever the queue has room.
	assign q_valid  = s_tvalid;
	assign s_tready = q_ready;

	// Classify the request; unused codes become a no-operation.
	always_comb begin
		q_cmd.pos  = position;
		q_cmd.elem = isl_pkg::ELEMENT_WIDTH'(element);
		unique case (req_type)
			isl_pkg::RT_PUSH:   q_cmd.op = isl_pkg::OP_PUSH;
			isl_pkg::RT_POP:    q_cmd.op = isl_pkg::OP_POP;
			isl_pkg::RT_INSERT: q_cmd.op = isl_pkg::OP_INSERT;
			isl_pkg::RT_REMOVE: q_cmd.op = isl_pkg::OP_REMOVE;
			isl_pkg::RT_GET:    q_cmd.op = isl_pkg::OP_GET;
			isl_pkg::RT_SET:    q_cmd.op = isl_pkg::OP_SET;
			default:            q_cmd.op = isl_pkg::OP_NOP;
		endcase
	end

endmodule

FILE: rtl/isl_fifo.sv
// ----------------------------------------------------------------------------
// Indexed shift list command queue
// A short first-in first-out queue of decoded commands between the front end
// and the execution engine.
// ----------------------------------------------------------------------------
module isl_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  isl_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output isl_pkg::cmd_t rd_data
);

	isl_pkg::cmd_t                mem_q [isl_pkg::QDEPTH];
	logic [isl_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [isl_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [isl_pkg::QCNT_W-1:0]   fill_q;
	logic                         do_wr;
	logic                         do_rd;

	assign wr_ready = (fill_q != isl_pkg::QCNT_W'(isl_pkg::QDEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/isl_back.sv
// ----------------------------------------------------------------------------
// Indexed shift list execution engine
// Holds the row of element cells and the count, runs one command at a time
// through a read step and an execute step, and keeps the result register.
// ----------------------------------------------------------------------------
module isl_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  isl_pkg::cmd_t                    cmd,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0 up: status (2), data_out (32), count_out (7), zero fill.
	output logic [isl_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic [isl_pkg::ELEMENT_WIDTH-1:0] cells_q [isl_pkg::CAPACITY];
	logic [isl_pkg::ELEMENT_WIDTH-1:0] grp_q   [isl_pkg::NGRP];
	logic [isl_pkg::ELEMENT_WIDTH-1:0] grp_d   [isl_pkg::NGRP];
	logic [isl_pkg::CNT_W-1:0]         count_q;
	logic [isl_pkg::CNT_W-1:0]         count_d;
	logic [isl_pkg::CNT_W-1:0]         cnt_m1;
	isl_pkg::bstate_t                  state_q;
	isl_pkg::bstate_t                  state_d;
	isl_pkg::cmd_t                     cmd_q;

	logic                              out_valid_q;
	isl_pkg::status_t                  out_status_q;
	logic [isl_pkg::DATA_FIELD_W-1:0]  out_data_q;
	logic [isl_pkg::COUNT_FIELD_W-1:0] out_count_q;

	logic                              out_free;
	logic                              load;
	logic                              commit;
	logic [isl_pkg::CMP_W-1:0]         pos_ext;
	logic [isl_pkg::CMP_W-1:0]         cnt_ext;
	logic [isl_pkg::IDX_W-1:0]         rd_idx;
	int                                rd_lo;
	int                                rd_hi;
	int                                pos_i;
	int                                cnt_i;
	logic [isl_pkg::ELEMENT_WIDTH-1:0] rd_data;
	logic                              full;
	logic                              empty;
	logic                              pos_lt_cnt;
	logic                              pos_le_cnt;
	isl_pkg::status_t                  status_d;
	logic [isl_pkg::ELEMENT_WIDTH-1:0] data_d;
	logic                              do_push;
	logic                              do_ins;
	logic                              do_rem;
	logic                              do_set;

	assign out_free = !out_valid_q || m_tready;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			isl_pkg::B_IDLE: begin
				if (cmd_valid) begin
					state_d = isl_pkg::B_READ;
				end
			end
			isl_pkg::B_READ: begin
				state_d = isl_pkg::B_EXEC;
			end
			isl_pkg::B_EXEC: begin
				if (out_free) begin
					state_d = isl_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = isl_pkg::B_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cmd_ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			isl_pkg::B_IDLE: cmd_ready = 1'b1;
			isl_pkg::B_EXEC: commit    = out_free;
			default: begin
				cmd_ready = 1'b0;
				commit    = 1'b0;
			end
		endcase
	end

	assign load = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isl_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command held for the read and execute steps.
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd;
		end
	end

	// Position and count at a common width; pop reads the last element.
	assign pos_ext = isl_pkg::CMP_W'(cmd_q.pos);
	assign cnt_ext = isl_pkg::CMP_W'(count_q);
	assign cnt_m1  = count_q - 1'b1;
	assign rd_idx  = (cmd_q.op == isl_pkg::OP_POP) ? cnt_m1[isl_pkg::IDX_W-1:0]
	                                               : pos_ext[isl_pkg::IDX_W-1:0];
	assign rd_lo   = int'(rd_idx) % isl_pkg::GRP;
	assign rd_hi   = int'(rd_idx) / isl_pkg::GRP;
	assign pos_i   = int'(pos_ext);
	assign cnt_i   = int'(cnt_ext);

	// First read level: pick one cell inside every group.
	always_comb begin
		for (int g = 0; g < isl_pkg::NGRP; g++) begin
			grp_d[g] = '0;
		end
		for (int k = 0; k < isl_pkg::CAPACITY; k++) begin
			if ((k % isl_pkg::GRP) == rd_lo) begin
				grp_d[k / isl_pkg::GRP] = cells_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == isl_pkg::B_READ) begin
			for (int g = 0; g < isl_pkg::NGRP; g++) begin
				grp_q[g] <= grp_d[g];
			end
		end
	end

	// Second read level: pick the addressed group.
	always_comb begin
		rd_data = '0;
		for (int g = 0; g < isl_pkg::NGRP; g++) begin
			if (g == rd_hi) begin
				rd_data = grp_q[g];
			end
		end
	end

	// Bounds and capacity checks, status and new count.
	assign full       = (count_q == isl_pkg::CNT_W'(isl_pkg::CAPACITY));
	assign empty      = (count_q == '0);
	assign pos_lt_cnt = (pos_ext < cnt_ext);
	assign pos_le_cnt = (pos_ext <= cnt_ext);

	always_comb begin
		status_d = isl_pkg::ST_OK;
		data_d   = '0;
		count_d  = count_q;
		do_push  = 1'b0;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		do_set   = 1'b0;
		unique case (cmd_q.op)
			isl_pkg::OP_PUSH: begin
				if (full) begin
					status_d = isl_pkg::ST_FULL;
				end else begin
					do_push = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			isl_pkg::OP_POP: begin
				if (empty) begin
					status_d = isl_pkg::ST_EMPTY;
				end else begin
					data_d  = rd_data;
					count_d = cnt_m1;
				end
			end
			isl_pkg::OP_INSERT: begin
				if (!pos_le_cnt) begin
					status_d = isl_pkg::ST_BOUNDS;
				end else if (full) begin
					status_d = isl_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			isl_pkg::OP_REMOVE: begin
				if (!pos_lt_cnt) begin
					status_d = isl_pkg::ST_BOUNDS;
				end else begin
					do_rem  = 1'b1;
					data_d  = rd_data;
					count_d = cnt_m1;
				end
			end
			isl_pkg::OP_GET: begin
				if (!pos_lt_cnt) begin
					status_d = isl_pkg::ST_BOUNDS;
				end else begin
					data_d = rd_data;
				end
			end
			isl_pkg::OP_SET: begin
				if (!pos_lt_cnt) begin
					status_d = isl_pkg::ST_BOUNDS;
				end else begin
					do_set = 1'b1;
				end
			end
			default: begin
				status_d = isl_pkg::ST_OK;
			end
		endcase
	end

	// Cell row: each cell loads the new element, loads a neighbor or holds, all in parallel.
	always_ff @(posedge clk) begin
		if (commit) begin
			for (int k = 0; k < isl_pkg::CAPACITY; k++) begin
				if (do_push && k == cnt_i) begin
					cells_q[k] <= cmd_q.elem;
				end else if (do_set && k == pos_i) begin
					cells_q[k] <= cmd_q.elem;
				end else if (do_ins && k == pos_i) begin
					cells_q[k] <= cmd_q.elem;
				end else if (do_ins && k > pos_i && k <= cnt_i) begin
					cells_q[k] <= cells_q[(k > 0) ? k - 1 : 0];
				end else if (do_rem && k >= pos_i && k + 1 < cnt_i) begin
					cells_q[k] <= cells_q[(k + 1 < isl_pkg::CAPACITY) ? k + 1 : k];
				end
			end
		end
	end

	// Element count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= count_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= status_d;
			out_data_q   <= isl_pkg::DATA_FIELD_W'(data_d);
			out_count_q  <= isl_pkg::COUNT_FIELD_W'(count_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = isl_pkg::OUT_TDATA_W'({out_count_q, out_data_q, out_status_q});

	// The count never goes past the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= isl_pkg::CNT_W'(isl_pkg::CAPACITY))
		else $error("element count exceeds capacity");

	// The execute step is always preceded by the read step.
	a_exec_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == isl_pkg::B_EXEC |->
			$past(state_q) == isl_pkg::B_READ || $past(state_q) == isl_pkg::B_EXEC)
		else $error("execute step entered without a read step");

	// The count changes only when a command completes.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(count_q))
		else $error("element count changed outside a completed command");

	// A new result appears only from a completed command.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(commit))
		else $error("result raised without a completed command");

endmodule

FILE: rtl/indexed_shift_list_unit.sv
// ----------------------------------------------------------------------------
// Indexed shift list unit
// Ordered list of elements with push, pop, insert, remove, get and set.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream and each yields exactly one result on the
// m_ stream, in request order. A request holds the operation, a position and
// an element; a result holds a status, the element read (zero when nothing is
// read or the request failed) and the element count after the request.
// Insert and remove move all later elements by one place in parallel.
// A front end decodes requests into a four-entry command queue, so requests
// are taken while the engine is busy until the queue fills.
// The engine handles one request at a time: in its idle, read and execute
// steps it takes a command, selects the addressed element through a
// registered two-level select over the cell row, then updates the cells and
// loads the result register.
// Reset empties the list and the queue; element storage is not cleared and is
// only read after it has been written. When the receiver stalls, the result
// stays in its register, the engine waits in its execute step, and the input
// side keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module indexed_shift_list_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0 up: req_type (3), position (7), element (32), zero fill.
	input  logic [isl_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0 up: status (2), data_out (32), count_out (7), zero fill.
	output logic [isl_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic          fq_wr_valid;
	logic          fq_wr_ready;
	isl_pkg::cmd_t fq_wr_data;
	logic          fq_rd_valid;
	logic          fq_rd_ready;
	isl_pkg::cmd_t fq_rd_data;

	// Request decode.
	isl_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (fq_wr_valid),
		.q_ready  (fq_wr_ready),
		.q_cmd    (fq_wr_data)
	);

	// Command queue.
	isl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_wr_valid),
		.wr_ready (fq_wr_ready),
		.wr_data  (fq_wr_data),
		.rd_valid (fq_rd_valid),
		.rd_ready (fq_rd_ready),
		.rd_data  (fq_rd_data)
	);

	// List storage and execution.
	isl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (fq_rd_valid),
		.cmd_ready (fq_rd_ready),
		.cmd       (fq_rd_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
